>>> rtl/hplt_pkg.sv
// Package for the HP lattice move energy tracker.
// Holds the item structs, opcodes, state and command types and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package hplt_pkg;

    localparam int IDX_W    = 6;
    localparam int CRD_IN_W = 7;
    localparam int OCC_W    = 7;
    localparam int ENERGY_W = 8;
    localparam int LEN_W    = 7;
    localparam int MASK_W   = 64;
    localparam int DELTA_W  = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;

    localparam int DEFAULT_LATTICE_SIDE = 128;
    localparam int DEFAULT_MAX_RESIDUES = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_RESIDUE_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 1'b1;

    localparam logic [1:0] DIR_ROW_UP   = 2'd0;
    localparam logic [1:0] DIR_ROW_DOWN = 2'd1;
    localparam logic [1:0] DIR_COL_UP   = 2'd2;
    localparam logic [1:0] DIR_COL_DOWN = 2'd3;

    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_MOVE1   = 2'd1,
        REQ_MOVE2   = 2'd2,
        REQ_QUERY   = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [IDX_W-1:0]    idx1;
        logic [CRD_IN_W-1:0] old_x1;
        logic [CRD_IN_W-1:0] old_y1;
        logic [CRD_IN_W-1:0] new_x1;
        logic [CRD_IN_W-1:0] new_y1;
        logic [IDX_W-1:0]    idx2;
        logic [CRD_IN_W-1:0] old_x2;
        logic [CRD_IN_W-1:0] old_y2;
        logic [CRD_IN_W-1:0] new_x2;
        logic [CRD_IN_W-1:0] new_y2;
    } in_item_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy_now;
        logic                       site_taken;
        logic [IDX_W-1:0]           site_residue;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CHECK,
        ST_QRD,
        ST_QEV,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_PLACE,
        ST_PB,
        ST_PA,
        ST_WR,
        ST_ACC,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SWEEP,
        OP_START,
        OP_CHECK,
        OP_QRD,
        OP_QEV,
        OP_CLR_RD,
        OP_CLR_WR,
        OP_PLACE,
        OP_PROBE_B,
        OP_PROBE_A,
        OP_WRITE,
        OP_UPD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   cnt_clr;
        logic   cnt_inc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_type;
        logic       is_move2;
        logic       move_ok;
        logic       count_zero;
        logic       sweep_last;
        logic       clr_last;
        logic       place_last;
        logic       probe_last;
        logic       wr_last;
        logic       out_busy;
    } status_t;

endpackage

>>> rtl/hp_lattice_move_energy_tracker_top.sv
// Top level of the HP lattice move energy tracker.
// Depends on hplt_pkg, hplt_ctrl, hplt_dpath (which holds the hplt_ram instances).
`timescale 1ns / 1ps

// Tracks an HP chain on a LATTICE_SIDE x LATTICE_SIDE square lattice and returns one
// result item per request item: the chain energy, plus the occupant for a site query.
// After reset the block sweeps the occupancy memory to empty, one site per cycle, and
// takes no request items until that is done; configuration writes are taken at any
// time. Restarts, queries and valid moves go through the occupancy memory, one read
// and one write a cycle, and that memory sets the timing.
// Steps: a query reads the one site; a one-site move makes four neighbour reads at the
// old site, four at the new site, then two writes; a two-site move makes eight reads,
// four writes, eight reads; a rejected move only checks; a restart clears each site
// of the previous chain, then places each residue of the new one.
// A new item is accepted the cycle after a result is loaded into the output register,
// even while that result waits for out_ready.
// Configuration: index 0 is residue_mask, index 1 chain_length (seen at the next restart).

module hp_lattice_move_energy_tracker_top #(
    parameter int LATTICE_SIDE = hplt_pkg::DEFAULT_LATTICE_SIDE,
    parameter int MAX_RESIDUES = hplt_pkg::DEFAULT_MAX_RESIDUES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  hplt_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hplt_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hplt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hplt_pkg::CFG_DATA_W-1:0] cfg_data
);

    hplt_pkg::cmd_t    cmd;
    hplt_pkg::status_t st;

    // config registers are always writable
    assign cfg_ready = 1'b1;

    hplt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    hplt_dpath #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .MAX_RESIDUES (MAX_RESIDUES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> rtl/hplt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hplt_ctrl.sv
// Sequencer for the HP lattice tracker: walks each request through its datapath steps.
// Depends on hplt_pkg.
`timescale 1ns / 1ps

module hplt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hplt_pkg::status_t st,
    output hplt_pkg::cmd_t    cmd
);

    hplt_pkg::state_t state_reg;
    hplt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hplt_pkg::ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = hplt_pkg::OP_NOP;
        cmd.cnt_clr = 1'b0;
        cmd.cnt_inc = 1'b0;
        in_ready    = 1'b0;
        case (state_reg)
            hplt_pkg::ST_SWEEP:
            begin
                cmd.op = hplt_pkg::OP_SWEEP;
                if (st.sweep_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = hplt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            hplt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op      = hplt_pkg::OP_START;
                    cmd.cnt_clr = 1'b1;
                    case (st.in_type)
                        hplt_pkg::REQ_RESTART:
                            state_next = st.count_zero ? hplt_pkg::ST_PLACE
                                                       : hplt_pkg::ST_CLR_RD;
                        hplt_pkg::REQ_MOVE1: state_next = hplt_pkg::ST_CHECK;
                        hplt_pkg::REQ_MOVE2: state_next = hplt_pkg::ST_CHECK;
                        default:             state_next = hplt_pkg::ST_QRD;
                    endcase
                end
            end
            hplt_pkg::ST_CHECK:
            begin
                cmd.op      = hplt_pkg::OP_CHECK;
                cmd.cnt_clr = 1'b1;
                state_next  = st.move_ok ? hplt_pkg::ST_PB : hplt_pkg::ST_DONE;
            end
            hplt_pkg::ST_PB:
            begin
                cmd.op = hplt_pkg::OP_PROBE_B;
                if (st.probe_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = st.is_move2 ? hplt_pkg::ST_WR : hplt_pkg::ST_PA;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            hplt_pkg::ST_PA:
            begin
                cmd.op = hplt_pkg::OP_PROBE_A;
                if (st.probe_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = st.is_move2 ? hplt_pkg::ST_ACC : hplt_pkg::ST_WR;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            hplt_pkg::ST_WR:
            begin
                cmd.op = hplt_pkg::OP_WRITE;
                if (st.wr_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = st.is_move2 ? hplt_pkg::ST_PA : hplt_pkg::ST_UPD;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            hplt_pkg::ST_ACC:
            begin
                state_next = hplt_pkg::ST_UPD;
            end
            hplt_pkg::ST_UPD:
            begin
                cmd.op     = hplt_pkg::OP_UPD;
                state_next = hplt_pkg::ST_DONE;
            end
            hplt_pkg::ST_CLR_RD:
            begin
                cmd.op     = hplt_pkg::OP_CLR_RD;
                state_next = hplt_pkg::ST_CLR_WR;
            end
            hplt_pkg::ST_CLR_WR:
            begin
                cmd.op = hplt_pkg::OP_CLR_WR;
                if (st.clr_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = hplt_pkg::ST_PLACE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = hplt_pkg::ST_CLR_RD;
                end
            end
            hplt_pkg::ST_PLACE:
            begin
                cmd.op = hplt_pkg::OP_PLACE;
                if (st.place_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = hplt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            hplt_pkg::ST_QRD:
            begin
                cmd.op     = hplt_pkg::OP_QRD;
                state_next = hplt_pkg::ST_QEV;
            end
            hplt_pkg::ST_QEV:
            begin
                cmd.op     = hplt_pkg::OP_QEV;
                state_next = hplt_pkg::ST_DONE;
            end
            hplt_pkg::ST_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.op     = hplt_pkg::OP_OUT;
                    state_next = hplt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hplt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/hplt_dpath.sv
// Datapath for the HP lattice tracker: config, occupancy and coordinate memories,
// contact counting, energy and the output register. Depends on hplt_pkg and hplt_ram.
`timescale 1ns / 1ps

module hplt_dpath #(
    parameter int LATTICE_SIDE = hplt_pkg::DEFAULT_LATTICE_SIDE,
    parameter int MAX_RESIDUES = hplt_pkg::DEFAULT_MAX_RESIDUES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hplt_pkg::in_item_t                  in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output hplt_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    input  logic [hplt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hplt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  hplt_pkg::cmd_t                      cmd,
    output hplt_pkg::status_t                   st
);

    localparam int CB    = $clog2(LATTICE_SIDE);
    localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW    = $clog2(SITES);
    localparam int RW    = $clog2(MAX_RESIDUES);
    localparam logic [CB-1:0] CENTRE  = CB'(LATTICE_SIDE / 2);
    localparam logic [CB-1:0] EDGE_HI = CB'(LATTICE_SIDE - 1);
    localparam logic [8:0]    SIDE9   = 9'(LATTICE_SIDE);
    localparam logic [hplt_pkg::LEN_W-1:0] MAXN = hplt_pkg::LEN_W'(MAX_RESIDUES);

    function automatic logic [AW-1:0] site_of(input logic [CB-1:0] x, input logic [CB-1:0] y);
        site_of = AW'(x) * AW'(LATTICE_SIDE) + AW'(y);
    endfunction

    function automatic logic on_lat(input logic [hplt_pkg::CRD_IN_W-1:0] c);
        on_lat = 9'(c) < SIDE9;
    endfunction

    // config and chain state
    logic [hplt_pkg::MASK_W-1:0]        mask_reg;
    logic [hplt_pkg::LEN_W-1:0]         len_reg;
    logic [hplt_pkg::LEN_W-1:0]         count_reg;
    logic signed [hplt_pkg::ENERGY_W-1:0] energy_reg;
    logic signed [hplt_pkg::DELTA_W-1:0]  delta_reg;
    logic [AW-1:0]                      cnt_reg;
    logic [CB-1:0]                      col_reg;
    hplt_pkg::in_item_t                 req_reg;
    logic                               taken_reg;
    logic [hplt_pkg::IDX_W-1:0]         who_reg;
    logic                               out_valid_reg;
    hplt_pkg::out_item_t                out_data_reg;

    // probe pipeline
    logic                               ev_live_reg;
    logic                               ev_neg_reg;
    logic [hplt_pkg::IDX_W-1:0]         ev_r_reg;

    // memory ports
    logic                               occ_we;
    logic [AW-1:0]                      occ_waddr;
    logic [hplt_pkg::OCC_W-1:0]         occ_wdata;
    logic [AW-1:0]                      occ_raddr;
    logic [hplt_pkg::OCC_W-1:0]         occ_rdata;
    logic                               crd_we;
    logic [RW-1:0]                      crd_waddr;
    logic [2*CB-1:0]                    crd_wdata;
    logic [RW-1:0]                      crd_raddr;
    logic [2*CB-1:0]                    crd_rdata;

    logic [hplt_pkg::LEN_W-1:0]         n_len;
    logic [hplt_pkg::LEN_W-1:0]         cnt7;
    logic                               move2;
    logic                               ok1;
    logic                               ok2;
    logic                               second;
    logic                               after;
    logic [CB-1:0]                      px;
    logic [CB-1:0]                      py;
    logic [CB-1:0]                      nbx;
    logic [CB-1:0]                      nby;
    logic                               nb_ok;
    logic [hplt_pkg::IDX_W-1:0]         pr;
    logic                               probe_live;
    logic [hplt_pkg::OCC_W-1:0]         held_j;
    logic [hplt_pkg::OCC_W-1:0]         r7;
    logic                               contact;
    logic signed [hplt_pkg::ENERGY_W:0] esum;
    logic signed [hplt_pkg::ENERGY_W-1:0] esat;
    logic [CB-1:0]                      ox1;
    logic [CB-1:0]                      oy1;
    logic [CB-1:0]                      nx1;
    logic [CB-1:0]                      ny1;
    logic [CB-1:0]                      ox2;
    logic [CB-1:0]                      oy2;
    logic [CB-1:0]                      nx2;
    logic [CB-1:0]                      ny2;

    always_comb
    begin
        ox1 = CB'(req_reg.old_x1);
        oy1 = CB'(req_reg.old_y1);
        nx1 = CB'(req_reg.new_x1);
        ny1 = CB'(req_reg.new_y1);
        ox2 = CB'(req_reg.old_x2);
        oy2 = CB'(req_reg.old_y2);
        nx2 = CB'(req_reg.new_x2);
        ny2 = CB'(req_reg.new_y2);

        // restart length, clamped
        n_len = len_reg;
        if (len_reg == '0)
        begin
            n_len = hplt_pkg::LEN_W'(1);
        end
        else if (len_reg > MAXN)
        begin
            n_len = MAXN;
        end
        cnt7  = hplt_pkg::LEN_W'(cnt_reg);
        move2 = (req_reg.req_type == hplt_pkg::REQ_MOVE2);

        ok1 = ({1'b0, req_reg.idx1} < count_reg) && on_lat(req_reg.old_x1)
              && on_lat(req_reg.old_y1) && on_lat(req_reg.new_x1) && on_lat(req_reg.new_y1);
        ok2 = ({1'b0, req_reg.idx2} < count_reg) && on_lat(req_reg.old_x2)
              && on_lat(req_reg.old_y2) && on_lat(req_reg.new_x2) && on_lat(req_reg.new_y2);

        // neighbour probe: residue by bit 2, direction by bits 1:0
        second = move2 && cnt_reg[2];
        after  = (cmd.op == hplt_pkg::OP_PROBE_A);
        if (second)
        begin
            px = after ? nx2 : ox2;
            py = after ? ny2 : oy2;
            pr = req_reg.idx2;
        end
        else
        begin
            px = after ? nx1 : ox1;
            py = after ? ny1 : oy1;
            pr = req_reg.idx1;
        end
        nbx = px;
        nby = py;
        case (cnt_reg[1:0])
            hplt_pkg::DIR_ROW_UP:
            begin
                nb_ok = (px != EDGE_HI);
                nbx   = px + CB'(1);
            end
            hplt_pkg::DIR_ROW_DOWN:
            begin
                nb_ok = (px != '0);
                nbx   = px - CB'(1);
            end
            hplt_pkg::DIR_COL_UP:
            begin
                nb_ok = (py != EDGE_HI);
                nby   = py + CB'(1);
            end
            default:
            begin
                nb_ok = (py != '0);
                nby   = py - CB'(1);
            end
        endcase
        probe_live = nb_ok && mask_reg[pr];

        // contact test on the site read in the previous cycle
        held_j  = occ_rdata - hplt_pkg::OCC_W'(1);
        r7      = {1'b0, ev_r_reg};
        contact = ev_live_reg && (occ_rdata != '0) && (held_j != r7)
                  && (held_j + hplt_pkg::OCC_W'(1) != r7) && (held_j != r7 + hplt_pkg::OCC_W'(1))
                  && mask_reg[held_j[hplt_pkg::IDX_W-1:0]];

        // saturating energy update
        esum = {energy_reg[hplt_pkg::ENERGY_W-1], energy_reg}
               + (hplt_pkg::ENERGY_W+1)'(delta_reg);
        if (esum < -(hplt_pkg::ENERGY_W+1)'(128))
        begin
            esat = -hplt_pkg::ENERGY_W'(128);
        end
        else if (esum > (hplt_pkg::ENERGY_W+1)'(0))
        begin
            esat = '0;
        end
        else
        begin
            esat = esum[hplt_pkg::ENERGY_W-1:0];
        end

        // occupancy memory
        occ_we    = 1'b0;
        occ_waddr = cnt_reg;
        occ_wdata = '0;
        occ_raddr = site_of(nbx, nby);
        crd_we    = 1'b0;
        crd_waddr = cnt_reg[RW-1:0];
        crd_wdata = {CENTRE, col_reg};
        crd_raddr = cnt_reg[RW-1:0];
        case (cmd.op)
            hplt_pkg::OP_SWEEP:
            begin
                occ_we = 1'b1;
            end
            hplt_pkg::OP_QRD:
            begin
                occ_raddr = site_of(ox1, oy1);
            end
            hplt_pkg::OP_CLR_WR:
            begin
                occ_we    = 1'b1;
                occ_waddr = site_of(crd_rdata[2*CB-1:CB], crd_rdata[CB-1:0]);
            end
            hplt_pkg::OP_PLACE:
            begin
                occ_we    = 1'b1;
                occ_waddr = site_of(CENTRE, col_reg);
                occ_wdata = hplt_pkg::OCC_W'(cnt7 + hplt_pkg::LEN_W'(1));
                crd_we    = 1'b1;
            end
            hplt_pkg::OP_WRITE:
            begin
                // move1: clear old1, place 1; move2: clear old1, clear old2, place 1, place 2
                if (!move2)
                begin
                    if (cnt_reg[0])
                    begin
                        occ_we    = 1'b1;
                        occ_waddr = site_of(nx1, ny1);
                        occ_wdata = hplt_pkg::OCC_W'(req_reg.idx1) + hplt_pkg::OCC_W'(1);
                        crd_we    = 1'b1;
                        crd_waddr = RW'(req_reg.idx1);
                        crd_wdata = {nx1, ny1};
                    end
                    else
                    begin
                        occ_we    = 1'b1;
                        occ_waddr = site_of(ox1, oy1);
                    end
                end
                else
                begin
                    case (cnt_reg[1:0])
                        2'd0:
                        begin
                            occ_we    = 1'b1;
                            occ_waddr = site_of(ox1, oy1);
                        end
                        2'd1:
                        begin
                            occ_we    = 1'b1;
                            occ_waddr = site_of(ox2, oy2);
                        end
                        2'd2:
                        begin
                            occ_we    = 1'b1;
                            occ_waddr = site_of(nx1, ny1);
                            occ_wdata = hplt_pkg::OCC_W'(req_reg.idx1) + hplt_pkg::OCC_W'(1);
                            crd_we    = 1'b1;
                            crd_waddr = RW'(req_reg.idx1);
                            crd_wdata = {nx1, ny1};
                        end
                        default:
                        begin
                            occ_we    = 1'b1;
                            occ_waddr = site_of(nx2, ny2);
                            occ_wdata = hplt_pkg::OCC_W'(req_reg.idx2) + hplt_pkg::OCC_W'(1);
                            crd_we    = 1'b1;
                            crd_waddr = RW'(req_reg.idx2);
                            crd_wdata = {nx2, ny2};
                        end
                    endcase
                end
            end
            default:
            begin
                occ_we = 1'b0;
            end
        endcase

        st.in_type    = in_data.req_type;
        st.is_move2   = move2;
        st.move_ok    = ok1 && (!move2 || ok2);
        st.count_zero = (count_reg == '0);
        st.sweep_last = (cnt_reg == AW'(SITES - 1));
        st.clr_last   = (cnt7 == count_reg - hplt_pkg::LEN_W'(1));
        st.place_last = (cnt7 == n_len - hplt_pkg::LEN_W'(1));
        st.probe_last = move2 ? (cnt_reg[2:0] == 3'd7) : (cnt_reg[1:0] == 2'd3);
        st.wr_last    = move2 ? (cnt_reg[1:0] == 2'd3) : cnt_reg[0];
        st.out_busy   = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            len_reg       <= hplt_pkg::LEN_W'(1);
            count_reg     <= '0;
            energy_reg    <= '0;
            delta_reg     <= '0;
            cnt_reg       <= '0;
            col_reg       <= '0;
            taken_reg     <= 1'b0;
            who_reg       <= '0;
            ev_live_reg   <= 1'b0;
            ev_neg_reg    <= 1'b0;
            ev_r_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    hplt_pkg::CFG_RESIDUE_MASK: mask_reg <= cfg_data;
                    default: len_reg <= cfg_data[hplt_pkg::LEN_W-1:0];
                endcase
            end

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end

            ev_live_reg <= probe_live && ((cmd.op == hplt_pkg::OP_PROBE_B) || after);
            ev_neg_reg  <= after;
            ev_r_reg    <= pr;
            if (cmd.op == hplt_pkg::OP_CHECK)
            begin
                delta_reg <= '0;
            end
            else if (contact)
            begin
                delta_reg <= ev_neg_reg ? delta_reg - hplt_pkg::DELTA_W'(1)
                                        : delta_reg + hplt_pkg::DELTA_W'(1);
            end

            case (cmd.op)
                hplt_pkg::OP_START:
                begin
                    taken_reg <= 1'b0;
                    who_reg   <= '0;
                    col_reg   <= CENTRE;
                end
                hplt_pkg::OP_PLACE:
                begin
                    col_reg <= (col_reg == EDGE_HI) ? '0 : col_reg + CB'(1);
                    if (st.place_last)
                    begin
                        count_reg  <= n_len;
                        energy_reg <= '0;
                    end
                end
                hplt_pkg::OP_QEV:
                begin
                    if (on_lat(req_reg.old_x1) && on_lat(req_reg.old_y1) && occ_rdata != '0)
                    begin
                        taken_reg <= 1'b1;
                        who_reg   <= held_j[hplt_pkg::IDX_W-1:0];
                    end
                end
                hplt_pkg::OP_UPD:
                begin
                    energy_reg <= esat;
                end
                default:
                begin
                    col_reg <= col_reg;
                end
            endcase

            if (cmd.op == hplt_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == hplt_pkg::OP_START)
        begin
            req_reg <= in_data;
        end
        if (cmd.op == hplt_pkg::OP_OUT)
        begin
            out_data_reg.energy_now   <= energy_reg;
            out_data_reg.site_taken   <= taken_reg;
            out_data_reg.site_residue <= who_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hplt_ram #(
        .WIDTH (hplt_pkg::OCC_W),
        .DEPTH (SITES)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    hplt_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_RESIDUES)
    ) u_crd_ram (
        .clk   (clk),
        .we    (crd_we),
        .waddr (crd_waddr),
        .wdata (crd_wdata),
        .raddr (crd_raddr),
        .rdata (crd_rdata)
    );

endmodule

>>> sim/hp_lattice_move_energy_tracker_top_tb.sv
// Self-checking testbench for hp_lattice_move_energy_tracker_top.
// Depends on hplt_pkg and the RTL; it runs its own lattice and energy model and
// compares every result item with it.
`timescale 1ns / 1ps

module hp_lattice_move_energy_tracker_top_tb;

    localparam int SIDE       = hplt_pkg::DEFAULT_LATTICE_SIDE;
    localparam int MAXRES     = hplt_pkg::DEFAULT_MAX_RESIDUES;
    localparam int CYCLE_CAP  = 2_000_000;

    // ---------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    logic                            in_valid = 1'b0;
    logic                            in_ready;
    hplt_pkg::in_item_t              in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    hplt_pkg::out_item_t             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hplt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hplt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    hp_lattice_move_energy_tracker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Lattice model: occupancy (0 empty, else residue+1), residue
    // coordinates, energy, and the chain length latched at restart.
    // ---------------------------------------------------------------
    logic [6:0]  site_owner [0:SIDE*SIDE-1];
    logic [6:0]  res_row [0:MAXRES-1];
    logic [6:0]  res_col [0:MAXRES-1];
    int          chain_energy;
    int          live_len;
    logic [63:0] h_mask;
    logic [6:0]  len_reg;

    const int d_row [4] = '{1, -1, 0, 0};
    const int d_col [4] = '{0, 0, 1, -1};

    hplt_pkg::in_item_t   pend_items [$];
    hplt_pkg::out_item_t  energy_expect [$];

    int errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_restart = 0;
    int n_move = 0;
    int n_query = 0;
    int n_phase = 0;
    bit quiet = 1'b0;      // when set, neither side idles

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH item %0d %s: got %0d expected %0d", n_checked, what, got, want);
    endtask

    function automatic int site_idx(input int x, input int y);
        return x * SIDE + y;
    endfunction

    // H-H contacts of residue r if it sat at (cx, cy), chain neighbours excluded
    function automatic int h_contacts(input int r, input int cx, input int cy);
        int cnt;
        int nx;
        int ny;
        int j;
        cnt = 0;
        if (!h_mask[r])
            return 0;
        for (int d = 0; d < 4; d++)
        begin
            nx = cx + d_row[d];
            ny = cy + d_col[d];
            if (nx < 0 || nx >= SIDE || ny < 0 || ny >= SIDE)
                continue;
            if (site_owner[site_idx(nx, ny)] == 0)
                continue;
            j = int'(site_owner[site_idx(nx, ny)]) - 1;
            if (j == r || j + 1 == r || j == r + 1)
                continue;
            if (h_mask[j])
                cnt++;
        end
        return cnt;
    endfunction

    function automatic void put_residue(input int r, input int x, input int y);
        site_owner[site_idx(x, y)] = 7'(r + 1);
        res_row[r] = 7'(x);
        res_col[r] = 7'(y);
    endfunction

    function automatic void add_energy(input int delta);
        chain_energy += delta;
        if (chain_energy < -128)
            chain_energy = -128;
        if (chain_energy > 0)
            chain_energy = 0;
    endfunction

    // Applies one accepted item to the model and returns the expected result
    function automatic hplt_pkg::out_item_t predict_energy(input hplt_pkg::in_item_t it);
        hplt_pkg::out_item_t o;
        int b;
        int a;
        int n;
        o = '0;
        case (hplt_pkg::req_type_t'(it.req_type))
            hplt_pkg::REQ_RESTART:
            begin
                for (int i = 0; i < live_len; i++)
                    site_owner[site_idx(res_row[i], res_col[i])] = '0;
                n = len_reg;
                if (n < 1)
                    n = 1;
                if (n > MAXRES)
                    n = MAXRES;
                for (int i = 0; i < n; i++)
                    put_residue(i, SIDE / 2, (SIDE / 2 + i) % SIDE);
                live_len = n;
                chain_energy = 0;
            end
            hplt_pkg::REQ_MOVE1:
            begin
                if (it.idx1 < live_len)
                begin
                    b = h_contacts(it.idx1, it.old_x1, it.old_y1);
                    a = h_contacts(it.idx1, it.new_x1, it.new_y1);
                    site_owner[site_idx(it.old_x1, it.old_y1)] = '0;
                    put_residue(it.idx1, it.new_x1, it.new_y1);
                    add_energy(b - a);
                end
            end
            hplt_pkg::REQ_MOVE2:
            begin
                if (it.idx1 < live_len && it.idx2 < live_len)
                begin
                    b = h_contacts(it.idx1, it.old_x1, it.old_y1)
                        + h_contacts(it.idx2, it.old_x2, it.old_y2);
                    site_owner[site_idx(it.old_x1, it.old_y1)] = '0;
                    site_owner[site_idx(it.old_x2, it.old_y2)] = '0;
                    put_residue(it.idx1, it.new_x1, it.new_y1);
                    put_residue(it.idx2, it.new_x2, it.new_y2);
                    a = h_contacts(it.idx1, it.new_x1, it.new_y1)
                        + h_contacts(it.idx2, it.new_x2, it.new_y2);
                    add_energy(b - a);
                end
            end
            default:
            begin
                if (site_owner[site_idx(it.old_x1, it.old_y1)] != 0)
                begin
                    o.site_taken = 1'b1;
                    o.site_residue = 6'(site_owner[site_idx(it.old_x1, it.old_y1)] - 1);
                end
            end
        endcase
        o.energy_now = 8'(chain_energy);
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: takes items from pend_items, random gap per item.
    // The model is advanced at the edge that accepts the item.
    // ---------------------------------------------------------------
    int in_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            nxt_valid = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                energy_expect.push_back(predict_energy(in_data));
                case (hplt_pkg::req_type_t'(in_data.req_type))
                    hplt_pkg::REQ_RESTART: n_restart++;
                    hplt_pkg::REQ_QUERY:   n_query++;
                    default:               n_move++;
                endcase
            end
            if (!nxt_valid)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (pend_items.size() > 0)
                begin
                    in_data   <= pend_items.pop_front();
                    nxt_valid = 1'b1;
                    in_gap    <= quiet ? 0 : $urandom_range(0, 4);
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random stall after each item, compare in order
    // ---------------------------------------------------------------
    int out_stall = 0;

    always @(posedge clk or negedge rst_n)
    begin
        int w;
        hplt_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            w = out_stall;
            if (out_valid && out_ready)
            begin
                if (energy_expect.size() == 0)
                begin
                    errors++;
                    $display("MISMATCH result item with nothing expected");
                end
                else
                begin
                    want = energy_expect.pop_front();
                    if (out_data.energy_now !== want.energy_now)
                        report("energy_now", out_data.energy_now, want.energy_now);
                    if (out_data.site_taken !== want.site_taken)
                        report("site_taken", out_data.site_taken, want.site_taken);
                    if (out_data.site_residue !== want.site_residue)
                        report("site_residue", out_data.site_residue, want.site_residue);
                end
                n_checked++;
                w = quiet ? 0 : $urandom_range(0, 4);
            end
            else if (w > 0)
                w--;
            out_stall <= w;
            out_ready <= (w == 0);
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     energy_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic wait_idle();
        @(negedge clk);
        while (pend_items.size() != 0 || in_valid || energy_expect.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [hplt_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == hplt_pkg::CFG_RESIDUE_MASK)
            h_mask = val;
        else
            len_reg = val[6:0];
    endtask

    // waits until the previous item has been accepted and applied to the model
    task automatic wait_free();
        @(negedge clk);
        while (pend_items.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    // one item queued for the driver at a time
    task automatic send(input hplt_pkg::in_item_t it);
        wait_free();
        pend_items.push_back(it);
        n_items++;
    endtask

    function automatic hplt_pkg::in_item_t rand_item(input hplt_pkg::req_type_t t);
        hplt_pkg::in_item_t it;
        it = hplt_pkg::in_item_t'($bits(hplt_pkg::in_item_t)'({$urandom, $urandom, $urandom}));
        it.req_type = t;
        return it;
    endfunction

    // neighbour step of (x, y); falls back to a random site at the edge
    function automatic void step_site(input int x, input int y, output int nx, output int ny);
        int d;
        d = $urandom_range(0, 3);
        nx = x + d_row[d];
        ny = y + d_col[d];
        if (nx < 0 || nx >= SIDE || ny < 0 || ny >= SIDE)
        begin
            nx = $urandom_range(0, SIDE - 1);
            ny = $urandom_range(0, SIDE - 1);
        end
    endfunction

    // Mostly consistent moves of live residues to a neighbour site; some
    // queries, some arbitrary or out-of-chain items, rare restarts.
    function automatic hplt_pkg::in_item_t make_item();
        hplt_pkg::in_item_t it;
        int k;
        int r;
        int nx;
        int ny;
        k = $urandom_range(0, 99);
        r = (live_len > 0) ? $urandom_range(0, live_len - 1) : 0;
        if (k < 3 || live_len == 0)
            it = rand_item(hplt_pkg::REQ_RESTART);
        else if (k < 16)
        begin
            it = rand_item(hplt_pkg::REQ_QUERY);
            if (k < 11)
            begin
                step_site(res_row[r], res_col[r], nx, ny);
                it.old_x1 = (k < 7) ? res_row[r] : 7'(nx);
                it.old_y1 = (k < 7) ? res_col[r] : 7'(ny);
            end
        end
        else if (k < 26)
            it = rand_item(hplt_pkg::req_type_t'($urandom_range(1, 3)));
        else
        begin
            it = rand_item((k < 70) ? hplt_pkg::REQ_MOVE1 : hplt_pkg::REQ_MOVE2);
            it.idx1   = 6'(r);
            it.old_x1 = res_row[r];
            it.old_y1 = res_col[r];
            step_site(res_row[r], res_col[r], nx, ny);
            it.new_x1 = 7'(nx);
            it.new_y1 = 7'(ny);
            r = $urandom_range(0, live_len - 1);
            it.idx2   = 6'(r);
            it.old_x2 = res_row[r];
            it.old_y2 = res_col[r];
            step_site(res_row[r], res_col[r], nx, ny);
            it.new_x2 = 7'(nx);
            it.new_y2 = 7'(ny);
        end
        return it;
    endfunction

    task automatic random_phase(input logic [63:0] m, input logic [6:0] len,
                                input int count, input bit no_idle);
        wait_idle();
        cfg_write(hplt_pkg::CFG_RESIDUE_MASK, m);
        cfg_write(hplt_pkg::CFG_CHAIN_LENGTH, {57'd0, len});
        quiet = no_idle;
        n_phase++;
        send(rand_item(hplt_pkg::REQ_RESTART));
        repeat (count)
        begin
            // build each item only once the model holds the current coordinates
            wait_free();
            send(make_item());
        end
    endtask

    initial
    begin
        hplt_pkg::in_item_t it;
        for (int i = 0; i < SIDE * SIDE; i++)
            site_owner[i] = '0;
        chain_energy = 0;
        live_len = 0;
        h_mask = '0;
        len_reg = 7'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: queries before any chain, zero length, edges of the
        // lattice, out-of-chain indexes, moves whose old site does not match.
        it = rand_item(hplt_pkg::REQ_QUERY);
        it.old_x1 = 7'd64;
        it.old_y1 = 7'd64;
        send(it);
        wait_idle();
        cfg_write(hplt_pkg::CFG_RESIDUE_MASK, '1);
        cfg_write(hplt_pkg::CFG_CHAIN_LENGTH, 64'd0);
        send(rand_item(hplt_pkg::REQ_RESTART));
        send(it);
        it.old_x1 = 7'd0;
        it.old_y1 = 7'd0;
        send(it);
        it.old_x1 = 7'd127;
        it.old_y1 = 7'd127;
        send(it);
        it = rand_item(hplt_pkg::REQ_MOVE1);
        it.idx1 = 6'd63;
        send(it);
        it = '0;
        it.req_type = hplt_pkg::REQ_MOVE1;
        it.old_x1 = 7'd64;
        it.old_y1 = 7'd64;
        it.new_x1 = 7'd65;
        it.new_y1 = 7'd64;
        send(it);
        it.old_x1 = 7'd0;
        it.old_y1 = 7'd0;
        it.new_x1 = 7'd127;
        it.new_y1 = 7'd127;
        send(it);
        it = '1;
        it.req_type = hplt_pkg::REQ_QUERY;
        send(it);
        it = rand_item(hplt_pkg::REQ_MOVE2);
        it.idx1 = 6'd0;
        it.idx2 = 6'd1;
        send(it);
        it = '0;
        it.req_type = hplt_pkg::REQ_MOVE2;
        it.old_x1 = 7'd127;
        it.old_y1 = 7'd127;
        it.new_x1 = 7'd64;
        it.new_y1 = 7'd66;
        it.old_x2 = 7'd64;
        it.old_y2 = 7'd66;
        it.new_x2 = 7'd63;
        it.new_y2 = 7'd66;
        send(it);
        send(rand_item(hplt_pkg::REQ_RESTART));
        it = rand_item(hplt_pkg::REQ_QUERY);
        it.old_x1 = 7'd65;       // stale occupant left by the mismatched move
        it.old_y1 = 7'd64;
        send(it);

        // Directed: over-long length clips, then fold a short chain into contacts
        wait_idle();
        cfg_write(hplt_pkg::CFG_CHAIN_LENGTH, 64'd127);
        send(rand_item(hplt_pkg::REQ_RESTART));
        wait_idle();
        cfg_write(hplt_pkg::CFG_CHAIN_LENGTH, 64'd4);
        send(rand_item(hplt_pkg::REQ_RESTART));
        it = '0;
        it.req_type = hplt_pkg::REQ_MOVE2;
        it.idx1 = 6'd2;
        it.old_x1 = 7'd64;
        it.old_y1 = 7'd66;
        it.new_x1 = 7'd65;
        it.new_y1 = 7'd65;
        it.idx2 = 6'd3;
        it.old_x2 = 7'd64;
        it.old_y2 = 7'd67;
        it.new_x2 = 7'd65;
        it.new_y2 = 7'd64;
        send(it);
        it = rand_item(hplt_pkg::REQ_QUERY);
        it.old_x1 = 7'd65;
        it.old_y1 = 7'd64;
        send(it);

        // Random phases across masks and lengths, one with no idling
        random_phase('1, 7'd64, 300, 1'b0);
        random_phase('0, 7'd127, 150, 1'b0);
        random_phase({$urandom, $urandom}, 7'($urandom_range(1, 64)), 300, 1'b0);
        random_phase('1, 7'd8, 250, 1'b1);
        random_phase({$urandom, $urandom}, 7'd64, 300, 1'b0);
        random_phase('1, 7'd2, 150, 1'b0);
        random_phase({$urandom, $urandom}, 7'($urandom_range(0, 127)), 150, 1'b0);

        wait_idle();
        repeat (200) @(negedge clk);

        $display("Sent %0d request items over %0d random phases, checked %0d results",
                 n_items, n_phase, n_checked);
        $display("  %0d restarts, %0d moves, %0d site queries, %0d mismatches",
                 n_restart, n_move, n_query, errors);
        if (errors == 0 && energy_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
